### rtl/core/opc_pkg.sv
package opc_pkg;

	// number of cordic micro-rotations per chain
	localparam int unsigned CORDIC_STAGES = 16;
	// fraction bits of the position words
	localparam int unsigned POSITION_FRACTION_BITS = 16;

	// width of the cell stage index (covers up to 32 stages)
	localparam int unsigned IDX_W = 5;
	// datapath width of the cordic vector components
	localparam int unsigned W = 36;
	// width of the cordic angle accumulator
	localparam int unsigned ZW = 34;

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;

	// reset threshold: 0.05 m rounded at the position scale, saturated
	localparam longint unsigned MIN_RAW =
		((64'd3355443 << POSITION_FRACTION_BITS) + (64'd1 << 25)) >> 26;
	localparam logic [15:0] MIN_RESET = (MIN_RAW > 64'd65535) ? 16'hFFFF : 16'(MIN_RAW);

	// arctangent of 2^-i in 32-bit binary angle
	localparam logic [31:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	// per-word side data travelling down the pipeline
	typedef struct packed {
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic [15:0] hd;
		logic [15:0] dh;
		logic [15:0] oh;
		logic [15:0] gh;
		logic vneg;
		logic vzero;
		logic bwd;
	} opc_side_t;

endpackage

### rtl/core/opc_cell.sv
module opc_cell (
	input  logic clk,
	input  logic en,
	input  logic vec,
	input  logic [opc_pkg::IDX_W-1:0] idx,
	input  logic signed [opc_pkg::W-1:0] x_i,
	input  logic signed [opc_pkg::W-1:0] y_i,
	input  logic signed [opc_pkg::ZW-1:0] z_i,
	output logic signed [opc_pkg::W-1:0] x_q,
	output logic signed [opc_pkg::W-1:0] y_q,
	output logic signed [opc_pkg::ZW-1:0] z_q
);
	import opc_pkg::*;

	logic signed [W-1:0] xs, ys;
	logic signed [ZW-1:0] a;
	logic up;

	// one micro-rotation: direction from angle sign or from y sign
	always_comb begin
		xs = x_i >>> idx;
		ys = y_i >>> idx;
		a = ZW'(ATAN_TAB[idx]);
		up = vec ? y_i[W-1] : !z_i[ZW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (up) begin
				x_q <= x_i - ys;
				y_q <= y_i + xs;
				z_q <= z_i - a;
			end else begin
				x_q <= x_i + ys;
				y_q <= y_i - xs;
				z_q <= z_i + a;
			end
		end
	end
endmodule

### rtl/core/odometry_pose_correction.sv
// Odometry pose correction: maps a sensor pose from odometry into global
// coordinates with a rotation, translation, rotation motion model.
// Input channel: in_valid/in_ready with sensor, odometry and global pose
// fields; one word is taken at each edge where both are high.
// Output channel: out_valid/out_ready with the corrected pose.
// cfg_we/cfg_wdata write min_translation; write it only while idle.
// Throughput: one word per cycle while out_ready is high. A word passes
// through the input register, two cordic chains in series (direction and
// distance, then the output rotation), the rotation angle register, the two
// gain multiply registers and the output register.
// Each pipeline position advances when it is empty or the next one moves,
// so bubbles close up and words keep entering while a result waits.
// When the receiver stalls, in_ready drops only once every position holds
// a word. Reset empties the pipeline and restores min_translation to
// 0.05 m at the position scale.
module odometry_pose_correction (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [31:0] sensor_x,
	input  logic signed [31:0] sensor_y,
	input  logic signed [15:0] sensor_heading,
	input  logic signed [31:0] odom_x,
	input  logic signed [31:0] odom_y,
	input  logic signed [15:0] odom_heading,
	input  logic signed [31:0] global_x,
	input  logic signed [31:0] global_y,
	input  logic signed [15:0] global_heading,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [31:0] corrected_x,
	output logic signed [31:0] corrected_y,
	output logic signed [15:0] corrected_heading,
	input  logic cfg_we,
	input  logic [15:0] cfg_wdata
);
	import opc_pkg::*;

	localparam int unsigned S = CORDIC_STAGES;
	localparam int unsigned P_G1 = S + 1;
	localparam int unsigned P_RO = S + 2;
	localparam int unsigned P_G2 = 2 * S + 3;
	localparam int unsigned N = 2 * S + 5;

	// gain removal: magnitude times 0x9B74EDA8 / 2^32, rounded half up
	function automatic logic [W-1:0] opc_gain(input logic [W-1:0] m);
		logic [W-33:0] hi;
		logic [31:0] lo;
		logic [63:0] p;
		logic [W-1:0] hk;
		hi = m[W-1:32];
		lo = m[31:0];
		p = 64'(lo) * 64'(INV_GAIN) + 64'h8000_0000;
		hk = W'(hi) * W'(INV_GAIN);
		return hk + W'(p[63:32]);
	endfunction

	logic [N-1:0] v_q;
	logic [N-1:0] en;
	opc_side_t side_q [N];
	opc_side_t side_d [N];
	logic [15:0] min_q;

	logic signed [31:0] sx_q, sy_q, ox_q, oy_q;
	logic [15:0] sh_q;
	logic signed [32:0] dx, dy;
	logic [31:0] ang_a, ang_c;
	logic fold_a, fold_c, vzero, vneg;

	logic signed [W-1:0] ax [S+1];
	logic signed [W-1:0] ay [S+1];
	logic signed [ZW-1:0] az [S+1];
	logic signed [W-1:0] bx [S+1];
	logic signed [W-1:0] by [S+1];
	logic signed [ZW-1:0] bz [S+1];
	logic signed [W-1:0] cx [S+1];
	logic signed [W-1:0] cy [S+1];
	logic signed [ZW-1:0] cz [S+1];

	logic [W-1:0] dt_q;
	logic [31:0] dir_q;
	logic short_c;
	logic [31:0] dh32, dr1;
	logic signed [W-1:0] cx0_q;
	logic [31:0] cang_q;
	logic [W-1:0] mx, my, rx_q, ry_q;
	logic nx_q, ny_q;
	logic signed [31:0] outx_q, outy_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
		end else if (cfg_we) begin
			min_q <= cfg_wdata;
		end
	end

	// advance enables: a position moves when empty or when its successor moves
	always_comb begin
		en[N-1] = !v_q[N-1] || out_ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < N; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	// input position
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sx_q <= sensor_x;
			sy_q <= sensor_y;
			ox_q <= odom_x;
			oy_q <= odom_y;
			sh_q <= sensor_heading;
		end
	end

	// chain setup: heading rotation of the motion and its vectoring
	always_comb begin
		dx = 33'(sx_q) - 33'(ox_q);
		dy = 33'(sy_q) - 33'(oy_q);
		ang_a = 32'd0 - {sh_q, 16'h0};
		fold_a = 1'(32'(ang_a + QUARTER_TURN) >> 31);
		ax[0] = fold_a ? -W'(dx) : W'(dx);
		ay[0] = fold_a ? -W'(dy) : W'(dy);
		az[0] = ZW'($signed(fold_a ? ang_a - HALF_TURN : ang_a));
		vzero = (dx == 33'sd0) && (dy == 33'sd0);
		vneg = dx[32];
		bx[0] = vneg ? -W'(dx) : W'(dx);
		by[0] = vneg ? -W'(dy) : W'(dy);
		bz[0] = '0;
	end

	// side data, with flags added where they are found
	always_comb begin
		side_d[0].gx = global_x;
		side_d[0].gy = global_y;
		side_d[0].hd = 16'(global_heading + sensor_heading - odom_heading);
		side_d[0].dh = 16'(sensor_heading - odom_heading);
		side_d[0].oh = odom_heading;
		side_d[0].gh = global_heading;
		side_d[0].vneg = 1'b0;
		side_d[0].vzero = 1'b0;
		side_d[0].bwd = 1'b0;
		for (int k = 1; k < N; k++) begin
			side_d[k] = side_q[k-1];
			if (k == 1) begin
				side_d[k].vneg = vneg && !vzero;
				side_d[k].vzero = vzero;
			end
			if (k == P_G1) side_d[k].bwd = ax[S][W-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (en[k]) side_q[k] <= side_d[k];
		end
	end

	// first row: rotation and vectoring cells side by side
	for (genvar k = 1; k <= S; k++) begin : g_ab
		opc_cell u_rot (
			.clk(clk), .en(en[k]), .vec(1'b0), .idx(IDX_W'(k - 1)),
			.x_i(ax[k-1]), .y_i(ay[k-1]), .z_i(az[k-1]),
			.x_q(ax[k]), .y_q(ay[k]), .z_q(az[k])
		);
		opc_cell u_vec (
			.clk(clk), .en(en[k]), .vec(1'b1), .idx(IDX_W'(k - 1)),
			.x_i(bx[k-1]), .y_i(by[k-1]), .z_i(bz[k-1]),
			.x_q(bx[k]), .y_q(by[k]), .z_q(bz[k])
		);
	end

	// distance and direction
	always_ff @(posedge clk) begin
		if (en[P_G1]) begin
			dt_q <= opc_gain(bx[S]);
			dir_q <= side_q[S].vzero ? 32'd0
				: ({side_q[S].vneg, 31'b0} + bz[S][31:0]);
		end
	end

	// first rotation and signed distance
	always_comb begin
		short_c = dt_q < W'(min_q);
		dh32 = {side_q[P_G1].dh, 16'h0};
		if (short_c) begin
			dr1 = {dh32[31], dh32[31:1]};
		end else begin
			dr1 = dir_q + (side_q[P_G1].bwd ? HALF_TURN : 32'd0)
				- {side_q[P_G1].oh, 16'h0};
		end
	end

	always_ff @(posedge clk) begin
		if (en[P_RO]) begin
			cx0_q <= side_q[P_G1].bwd ? -$signed(dt_q) : $signed(dt_q);
			cang_q <= {side_q[P_G1].gh, 16'h0} + dr1;
		end
	end

	// output rotation setup
	always_comb begin
		fold_c = 1'(32'(cang_q + QUARTER_TURN) >> 31);
		cx[0] = fold_c ? -cx0_q : cx0_q;
		cy[0] = '0;
		cz[0] = ZW'($signed(fold_c ? cang_q - HALF_TURN : cang_q));
	end

	// second row: output rotation cells
	for (genvar k = 1; k <= S; k++) begin : g_c
		opc_cell u_out (
			.clk(clk), .en(en[P_RO+k]), .vec(1'b0), .idx(IDX_W'(k - 1)),
			.x_i(cx[k-1]), .y_i(cy[k-1]), .z_i(cz[k-1]),
			.x_q(cx[k]), .y_q(cy[k]), .z_q(cz[k])
		);
	end

	// per-axis gain removal on magnitudes
	always_comb begin
		mx = cx[S][W-1] ? W'(-cx[S]) : W'(cx[S]);
		my = cy[S][W-1] ? W'(-cy[S]) : W'(cy[S]);
	end

	always_ff @(posedge clk) begin
		if (en[P_G2]) begin
			rx_q <= opc_gain(mx);
			ry_q <= opc_gain(my);
			nx_q <= cx[S][W-1];
			ny_q <= cy[S][W-1];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			outx_q <= side_q[P_G2].gx + (nx_q ? -rx_q[31:0] : rx_q[31:0]);
			outy_q <= side_q[P_G2].gy + (ny_q ? -ry_q[31:0] : ry_q[31:0]);
		end
	end

	assign out_valid = v_q[N-1];
	assign corrected_x = outx_q;
	assign corrected_y = outy_q;
	assign corrected_heading = side_q[N-1].hd;

	// input stalls only when every position holds a word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&v_q))
		else $error("input stalled with an empty pipeline position");

	// vectoring magnitude never goes negative
	a_vec_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[S] |-> !bx[S][W-1])
		else $error("negative vectoring magnitude");

	// zero threshold never selects the split rotation
	a_zero_min: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[P_G1] && (min_q == 16'd0)) |-> !short_c)
		else $error("short motion taken with zero threshold");
endmodule
